### hdl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants for the cluster member table.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int OP_W      = 1;
  localparam int CLUSTER_W = 8;
  localparam int NODE_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_JOIN  = 1'b0;
  localparam logic [OP_W-1:0] OP_LEAVE = 1'b1;

  localparam int CLUSTER_COUNT_DEF = 256;
  localparam int MAX_MEMBERS_DEF   = 64;

  // queued request, classified by the front end
  typedef struct packed {
    logic                 leave;
    logic                 in_range;
    logic [CLUSTER_W-1:0] cluster;
    logic [NODE_W-1:0]    node;
    logic [SLOT_W-1:0]    slot;
  } req_t;

endpackage

### hdl/cmt_in_if.sv
// ----------------------------------------------------------------------------
// cmt_in_if
// Request channel: op, cluster, node and slot with valid/ready.
// ----------------------------------------------------------------------------
interface cmt_in_if;
  import cmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [CLUSTER_W-1:0] cluster;
  logic [NODE_W-1:0]    node;
  logic [SLOT_W-1:0]    slot;

  modport source (output valid, output op, output cluster, output node, output slot,
                  input ready);
  modport sink   (input valid, input op, input cluster, input node, input slot,
                  output ready);
endinterface

### hdl/cmt_out_if.sv
// ----------------------------------------------------------------------------
// cmt_out_if
// Response channel: accepted flag with valid/ready.
// ----------------------------------------------------------------------------
interface cmt_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

### hdl/cmt_ram.sv
// ----------------------------------------------------------------------------
// cmt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cmt_front.sv
// ----------------------------------------------------------------------------
// cmt_front
// Accepts request words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cmt_front #(
  parameter int CLUSTER_COUNT = cmt_pkg::CLUSTER_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cmt_in_if.sink        req,
  input  logic          init_busy,
  output cmt_pkg::req_t head,
  output logic          head_valid,
  input  logic          pop
);
  import cmt_pkg::*;

  req_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  req_t       entry;

  assign req.ready  = (q_cnt != 2'd2) && !init_busy;
  assign push       = req.valid && req.ready;
  assign head_valid = (q_cnt != 2'd0);
  assign head       = q[rd_ptr];

  always_comb begin
    entry.leave    = (req.op == OP_LEAVE);
    entry.in_range = (32'(req.cluster) < 32'(CLUSTER_COUNT));
    entry.cluster  = req.cluster;
    entry.node     = req.node;
    entry.slot     = req.slot;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

### hdl/cmt_back.sv
// ----------------------------------------------------------------------------
// cmt_back
// Executes queued joins and leaves against the count and member RAMs.
// ----------------------------------------------------------------------------
module cmt_back #(
  parameter int CLUSTER_COUNT = cmt_pkg::CLUSTER_COUNT_DEF,
  parameter int MAX_MEMBERS   = cmt_pkg::MAX_MEMBERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cmt_pkg::CAP_W-1:0] capacity,
  input  cmt_pkg::req_t             head,
  input  logic                      head_valid,
  output logic                      pop,
  output logic                      init_busy,
  cmt_out_if.source                 rsp
);
  import cmt_pkg::*;

  localparam int CL_DEPTH = (CLUSTER_COUNT < (1 << CLUSTER_W)) ? CLUSTER_COUNT
                                                               : (1 << CLUSTER_W);
  localparam int CLW      = (CL_DEPTH > 1) ? $clog2(CL_DEPTH) : 1;
  localparam int MW       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CW       = $clog2(MAX_MEMBERS + 1);
  localparam int CMP_W    = (CW > CAP_W) ? CW : CAP_W;
  localparam int SC_W     = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int CNT_DEPTH = 1 << CLW;
  localparam int ID_DEPTH  = 1 << (CLW + MW);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MOV  = 3'd4;

  logic [2:0]      state, state_next;
  logic [CLW-1:0]  clr_idx;
  req_t            cur;
  logic [CW-1:0]   n_reg, n_next;
  logic            res_valid, res_valid_next;
  logic            res_acc, res_acc_next;

  logic            cnt_we;
  logic [CLW-1:0]  cnt_waddr;
  logic [CW-1:0]   cnt_wdata;
  logic [CW-1:0]   cnt_rdata;
  logic            ids_we;
  logic [CLW+MW-1:0] ids_waddr, ids_raddr;
  logic [NODE_W-1:0] ids_wdata, ids_rdata;

  logic [CLW-1:0]  cl_cur;
  logic [SC_W-1:0] slot_ext, n_ext;
  logic [MW-1:0]   slot_idx, tail_idx;
  logic [CW-1:0]   last;
  logic [CMP_W-1:0] cap_ext, cap_eff, n_cmp;

  assign cl_cur   = cur.cluster[CLW-1:0];
  assign slot_ext = SC_W'(cur.slot);
  assign slot_idx = slot_ext[MW-1:0];
  assign n_ext    = SC_W'(cnt_rdata);
  assign last     = n_reg - CW'(1);
  assign tail_idx = last[MW-1:0];
  assign cap_ext  = CMP_W'(capacity);
  assign cap_eff  = (cap_ext > CMP_W'(MAX_MEMBERS)) ? CMP_W'(MAX_MEMBERS) : cap_ext;
  assign n_cmp    = CMP_W'(cnt_rdata);

  assign init_busy    = (state == S_CLR);
  assign rsp.valid    = res_valid;
  assign rsp.accepted = res_acc;

  always_comb begin
    state_next     = state;
    n_next         = n_reg;
    pop            = 1'b0;
    res_valid_next = res_valid && !rsp.ready;
    res_acc_next   = res_acc;
    cnt_we         = 1'b0;
    cnt_waddr      = cl_cur;
    cnt_wdata      = last;
    ids_we         = 1'b0;
    ids_waddr      = {cl_cur, slot_idx};
    ids_wdata      = ids_rdata;
    ids_raddr      = {cl_cur, slot_idx};
    case (state)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        cnt_wdata = '0;
        if (clr_idx == {CLW{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // one item in flight; start only once the last result is gone
        if (head_valid && !res_valid) begin
          pop = 1'b1;
          if (head.in_range) begin
            state_next = S_CNT;
          end else begin
            res_valid_next = 1'b1;
            res_acc_next   = 1'b0;
          end
        end
      end
      S_CNT: begin
        n_next = cnt_rdata;
        if (!cur.leave) begin
          state_next     = S_IDLE;
          res_valid_next = 1'b1;
          if (n_cmp >= cap_eff) begin
            res_acc_next = 1'b0;
          end else begin
            res_acc_next = 1'b1;
            ids_we       = 1'b1;
            ids_waddr    = {cl_cur, cnt_rdata[MW-1:0]};
            ids_wdata    = cur.node;
            cnt_we       = 1'b1;
            cnt_wdata    = cnt_rdata + CW'(1);
          end
        end else if (slot_ext >= n_ext) begin
          state_next     = S_IDLE;
          res_valid_next = 1'b1;
          res_acc_next   = 1'b0;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        ids_raddr = {cl_cur, tail_idx};
        if (ids_rdata != cur.node) begin
          state_next     = S_IDLE;
          res_valid_next = 1'b1;
          res_acc_next   = 1'b0;
        end else if (slot_idx == tail_idx) begin
          // removing the tail: only the count drops
          state_next     = S_IDLE;
          res_valid_next = 1'b1;
          res_acc_next   = 1'b1;
          cnt_we         = 1'b1;
        end else begin
          state_next = S_MOV;
        end
      end
      S_MOV: begin
        // tail word now on read data; move it into the freed slot
        state_next     = S_IDLE;
        res_valid_next = 1'b1;
        res_acc_next   = 1'b1;
        ids_we         = 1'b1;
        cnt_we         = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (state == S_CLR) begin
        clr_idx <= clr_idx + CLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_reg   <= n_next;
    res_acc <= res_acc_next;
    if (pop) begin
      cur <= head;
    end
  end

  cmt_ram #(
    .WIDTH (CW),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (head.cluster[CLW-1:0]),
    .rdata (cnt_rdata)
  );

  cmt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (ID_DEPTH)
  ) u_ids_ram (
    .clk   (clk),
    .we    (ids_we),
    .waddr (ids_waddr),
    .wdata (ids_wdata),
    .raddr (ids_raddr),
    .rdata (ids_rdata)
  );

`ifndef SYNTHESIS
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (!pop && !res_valid))
    else $error("activity during count clear");

  a_busy_no_res: assert property (@(posedge clk) disable iff (rst)
    (state == S_CNT || state == S_CHK || state == S_MOV) |-> !res_valid)
    else $error("result pending while item in flight");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_we && state != S_CLR) |-> (cnt_wdata <= CW'(MAX_MEMBERS)))
    else $error("count exceeds list stride");

  a_res_once: assert property (@(posedge clk) disable iff (rst)
    (res_valid && rsp.ready) |=> !res_valid)
    else $error("back-to-back result without a new item");
`endif

endmodule

### hdl/cluster_member_table_core.sv
// ----------------------------------------------------------------------------
// cluster_member_table_core
// Per-cluster member lists with append on join and swap-remove on leave.
// ----------------------------------------------------------------------------
// After reset the block clears the count RAM word by word (256 words by
// default) and holds req.ready low meanwhile; capacity writes are taken
// throughout. A two-word queue decouples the request port from the
// execution sequencer, which handles one word at a time: a join checks the
// count against the capacity and appends; a leave checks its slot against
// the count, then the id in that slot, then, unless it is the tail, fetches
// the tail word through the single read port of the member RAM and moves it
// into the slot. A refused out-of-range cluster is answered straight from
// idle. The next word starts only once the previous response has been taken.
module cluster_member_table_core #(
  parameter int CLUSTER_COUNT = cmt_pkg::CLUSTER_COUNT_DEF,
  parameter int MAX_MEMBERS   = cmt_pkg::MAX_MEMBERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cmt_pkg::CAP_W-1:0] cfg_wdata,
  cmt_in_if.sink                    req,
  cmt_out_if.source                 rsp
);
  import cmt_pkg::*;

  logic [CAP_W-1:0] capacity;
  req_t             head;
  logic             head_valid;
  logic             pop;
  logic             init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  cmt_front #(
    .CLUSTER_COUNT (CLUSTER_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .init_busy  (init_busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  cmt_back #(
    .CLUSTER_COUNT (CLUSTER_COUNT),
    .MAX_MEMBERS   (MAX_MEMBERS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .init_busy  (init_busy),
    .rsp        (rsp)
  );

endmodule
